[design/hlm_pkg.sv]
// Shared types and constants of the heartbeat loss monitor.
`timescale 1ns / 1ps

package hlm_pkg;

  localparam int NUM_CORES_DEF = 4;
  localparam int HW_CORES      = 4;
  localparam int TimeW         = 32;
  localparam int DivW          = 8;
  localparam int CoreIdW       = 2;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 32;

  localparam logic REQ_TICK      = 1'b0;
  localparam logic REQ_HEARTBEAT = 1'b1;

  localparam logic [CfgIdxW-1:0] RegTimeout0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTimeout2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTimeout3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRunDivisor = 3'd4;

  localparam logic [TimeW-1:0] TimeoutReset = 32'd10;
  localparam logic [DivW-1:0]  DivisorReset = 8'd1;

  typedef struct packed {
    logic [TimeW-1:0] cur;
    logic [TimeW-1:0] heard;
    logic [TimeW-1:0] prev_seq;
    logic             loss;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HB_CHK,
    ST_EV_CHK,
    ST_EV_FLUSH
  } state_e;

endpackage

[design/hlm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module hlm_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/hlm_cfg.sv]
// Configuration registers: per-core timeouts and the run divisor.
`timescale 1ns / 1ps

module hlm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hlm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hlm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [hlm_pkg::CoreIdW-1:0]   core_sel_i,
  output logic [hlm_pkg::TimeW-1:0]     timeout_o,
  output logic [hlm_pkg::DivW-1:0]      run_div_o
);

  import hlm_pkg::*;

  logic [TimeW-1:0] timeout_q [HW_CORES];
  logic [TimeW-1:0] timeout_d [HW_CORES];
  logic [DivW-1:0]  run_div_q, run_div_d;

  always_comb begin
    timeout_d = timeout_q;
    run_div_d = run_div_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        RegTimeout0, RegTimeout1, RegTimeout2, RegTimeout3: begin
          timeout_d[cfg_idx_i[CoreIdW-1:0]] = cfg_wdata_i[TimeW-1:0];
        end
        RegRunDivisor: begin
          run_div_d = cfg_wdata_i[DivW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HW_CORES; i++) begin
        timeout_q[i] <= TimeoutReset;
      end
      run_div_q <= DivisorReset;
    end else begin
      timeout_q <= timeout_d;
      run_div_q <= run_div_d;
    end
  end

  assign timeout_o = timeout_q[core_sel_i];
  assign run_div_o = run_div_q;

endmodule

[design/heartbeat_loss_monitor_unit.sv]
// Top level of the heartbeat loss monitor: sequencer around the per-core state RAM.
//
// Input channel (in_valid_i/in_ready_o) takes ticks and heartbeats. A heartbeat
// checks the core's sequence number and, when accepted, stamps its last-heard
// time; it yields no result (RAM read, then write back).
// A tick advances the divider; a tick that does not reach run_divisor does
// nothing more. An evaluating tick visits each monitored core once, in turn,
// through the single read and write port of the state RAM, then releases the
// final result in a flush state.
// Each loss-flag change gives one transfer on the output channel
// (out_valid_o/out_ready_i); the last transfer of a tick carries last_o.
// One result is held back until the next is known, so last_o is exact.
// A stalled receiver holds the output register; the sequencer waits whenever
// a held result must leave while the output is still full.
// Configuration writes (cfg_we_i) take effect at once; write while idle.
// Reset clears all core state through per-entry valid bits, the divider and
// the output; timeouts return to 10 and the divisor to 1.

`timescale 1ns / 1ps

module heartbeat_loss_monitor_unit #(
  parameter int NumCores = hlm_pkg::NUM_CORES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hlm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hlm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [hlm_pkg::CoreIdW-1:0]   core_id_i,
  input  logic [hlm_pkg::TimeW-1:0]     running_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hlm_pkg::CoreIdW-1:0]   lost_core_o,
  output logic                          loss_active_o,
  output logic                          last_o
);

  import hlm_pkg::*;

  localparam int ActCores = (NumCores < HW_CORES) ? NumCores : HW_CORES;
  localparam int AddrW    = (ActCores > 1) ? $clog2(ActCores) : 1;
  localparam int EntryW   = $bits(entry_t);

  state_e state_q, state_d;

  logic [AddrW-1:0]    cnt_q, cnt_d;
  logic [DivW-1:0]     div_q, div_d;
  logic [AddrW-1:0]    hb_core_q, hb_core_d;
  logic [TimeW-1:0]    hb_count_q, hb_count_d;
  logic [ActCores-1:0] vld_q, vld_d;
  logic                rd_vld_q, rd_vld_d;
  logic                pend_vld_q, pend_vld_d;
  logic [AddrW-1:0]    pend_core_q, pend_core_d;
  logic                pend_act_q, pend_act_d;
  logic                out_valid_q, out_valid_d;
  logic [CoreIdW-1:0]  out_core_q, out_core_d;
  logic                out_act_q, out_act_d;
  logic                out_last_q, out_last_d;

  logic             ram_re, ram_we;
  logic [AddrW-1:0] ram_raddr, ram_waddr;
  entry_t           ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  entry_t           ent, upd;
  logic [TimeW-1:0] timeout_sel;
  logic [DivW-1:0]  run_div;
  logic [DivW-1:0]  div_inc;
  logic             hb_ok, tick_eval, hb_take;
  logic             err, chg, out_free, stall, last_core;

  hlm_ram #(
    .Width (EntryW),
    .Depth (ActCores)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hlm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .core_sel_i  (CoreIdW'(cnt_q)),
    .timeout_o   (timeout_sel),
    .run_div_o   (run_div)
  );

  assign ent = rd_vld_q ? entry_t'(ram_rdata) : '0;

  assign div_inc   = div_q + 1'b1;
  assign tick_eval = (div_inc >= run_div);
  assign hb_ok     = ({1'b0, core_id_i} < (CoreIdW + 1)'(ActCores));
  assign hb_take   = (hb_count_q >= (ent.prev_seq + 1'b1));

  always_comb begin
    upd = ent;
    if (ent.cur == '1) begin
      upd.cur   = '0;
      upd.heard = '0;
    end else begin
      upd.cur = ent.cur + 1'b1;
    end
    err      = (upd.heard > upd.cur) || ((upd.cur - upd.heard) >= timeout_sel);
    chg      = (err != ent.loss);
    upd.loss = err;
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign stall     = chg && pend_vld_q && !out_free;
  assign last_core = (cnt_q == AddrW'(ActCores - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_HEARTBEAT) begin
            if (hb_ok) begin
              state_d = ST_HB_CHK;
            end
          end else if (tick_eval) begin
            state_d = ST_EV_CHK;
          end
        end
      end
      ST_HB_CHK: begin
        state_d = ST_IDLE;
      end
      ST_EV_CHK: begin
        if (!stall && last_core) begin
          state_d = ST_EV_FLUSH;
        end
      end
      ST_EV_FLUSH: begin
        if (!pend_vld_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_re      = 1'b0;
    ram_raddr   = cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = upd;
    cnt_d       = cnt_q;
    div_d       = div_q;
    hb_core_d   = hb_core_q;
    hb_count_d  = hb_count_q;
    vld_d       = vld_q;
    pend_vld_d  = pend_vld_q;
    pend_core_d = pend_core_q;
    pend_act_d  = pend_act_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_core_d  = out_core_q;
    out_act_d   = out_act_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_HEARTBEAT) begin
            if (hb_ok) begin
              ram_re     = 1'b1;
              ram_raddr  = core_id_i[AddrW-1:0];
              hb_core_d  = core_id_i[AddrW-1:0];
              hb_count_d = running_count_i;
            end
          end else if (tick_eval) begin
            div_d     = '0;
            cnt_d     = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
          end else begin
            div_d = div_inc;
          end
        end
      end
      ST_HB_CHK: begin
        if (hb_take) begin
          ram_we          = 1'b1;
          ram_waddr       = hb_core_q;
          ram_wdata       = ent;
          ram_wdata.heard = ent.cur;
          ram_wdata.prev_seq = hb_count_q;
          vld_d[hb_core_q] = 1'b1;
        end
      end
      ST_EV_CHK: begin
        if (!stall) begin
          ram_we       = 1'b1;
          vld_d[cnt_q] = 1'b1;
          if (chg) begin
            pend_vld_d  = 1'b1;
            pend_core_d = cnt_q;
            pend_act_d  = err;
            if (pend_vld_q) begin
              out_valid_d = 1'b1;
              out_core_d  = CoreIdW'(pend_core_q);
              out_act_d   = pend_act_q;
              out_last_d  = 1'b0;
            end
          end
          if (!last_core) begin
            cnt_d     = AddrW'(cnt_q + 1'b1);
            ram_re    = 1'b1;
            ram_raddr = AddrW'(cnt_q + 1'b1);
          end
        end
      end
      ST_EV_FLUSH: begin
        if (pend_vld_q && out_free) begin
          pend_vld_d  = 1'b0;
          out_valid_d = 1'b1;
          out_core_d  = CoreIdW'(pend_core_q);
          out_act_d   = pend_act_q;
          out_last_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_vld_d = ram_re ? vld_q[ram_raddr] : rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      div_q       <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      div_q       <= div_d;
      vld_q       <= vld_d;
      rd_vld_q    <= rd_vld_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hb_core_q   <= hb_core_d;
    hb_count_q  <= hb_count_d;
    pend_core_q <= pend_core_d;
    pend_act_q  <= pend_act_d;
    out_core_q  <= out_core_d;
    out_act_q   <= out_act_d;
    out_last_q  <= out_last_d;
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign lost_core_o   = out_core_q;
  assign loss_active_o = out_act_q;
  assign last_o        = out_last_q;

endmodule

[tb/tb.sv]
// Testbench for the heartbeat loss monitor: directed table, random phases, self-checking.
`timescale 1ns / 1ps

module tb;
  import hlm_pkg::*;

  localparam int MonitoredCores = (NUM_CORES_DEF < HW_CORES) ? NUM_CORES_DEF : HW_CORES;
  localparam int SettleCycles   = 16;
  localparam int CycleLimit     = 400000;
  localparam int PhaseItems     = 50;
  localparam int SlowTicks      = 8;
  localparam logic [CfgIdxW-1:0] RegSpare    = 3'd5;
  localparam logic [DivW-1:0]    DivisorMax  = 8'hFF;
  localparam logic [TimeW-1:0]   TimeAllOnes = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [CoreIdW-1:0] core;
    logic               active;
    logic               last;
  } loss_event_t;

  typedef enum logic [1:0] {ROW_REG, ROW_TICK, ROW_BEAT} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CoreIdW-1:0]     core;
    logic [CfgDataW-1:0]    val;
    logic [CfgIdxW-1:0]     idx;
    logic                   typed;
    logic [1:0]             n_typed;
    loss_event_t [1:0]      typed_ev;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                req_type_i = REQ_TICK;
  logic [CoreIdW-1:0]  core_id_i = '0;
  logic [TimeW-1:0]    running_count_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CoreIdW-1:0]  lost_core_o;
  logic                loss_active_o;
  logic                last_o;

  logic [TimeW-1:0] timeout_cfg [HW_CORES];
  logic [DivW-1:0]  divisor_cfg;
  logic [TimeW-1:0] now_at [HW_CORES];
  logic [TimeW-1:0] heard_at [HW_CORES];
  logic [TimeW-1:0] seq_prev [HW_CORES];
  logic             lost_flag [HW_CORES];
  logic [DivW-1:0]  tick_div;

  loss_event_t fresh_events [$];
  loss_event_t pending_events [$];
  dir_row_t    dir_rows [$];
  loss_event_t want;

  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  bit          failed = 1'b0;
  int unsigned cycle_count = 0;

  heartbeat_loss_monitor_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .core_id_i       (core_id_i),
    .running_count_i (running_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lost_core_o     (lost_core_o),
    .loss_active_o   (loss_active_o),
    .last_o          (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, got core %0d active %0d last %0d",
                 $time, lost_core_o, loss_active_o, last_o);
        failed = 1'b1;
      end else begin
        want = pending_events.pop_front();
        if (lost_core_o !== want.core) begin
          $display("%0t: lost_core expected %0d, got %0d", $time, want.core, lost_core_o);
          failed = 1'b1;
        end
        if (loss_active_o !== want.active) begin
          $display("%0t: loss_active expected %0d, got %0d", $time, want.active,
                   loss_active_o);
          failed = 1'b1;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0d, got %0d", $time, want.last, last_o);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic void reset_monitor();
    for (int c = 0; c < HW_CORES; c++) begin
      timeout_cfg[c] = TimeoutReset;
      now_at[c]      = '0;
      heard_at[c]    = '0;
      seq_prev[c]    = '0;
      lost_flag[c]   = 1'b0;
    end
    divisor_cfg = DivisorReset;
    tick_div    = '0;
  endfunction

  function automatic void advance_monitor(logic req, logic [CoreIdW-1:0] core,
                                          logic [TimeW-1:0] count);
    logic [TimeW-1:0] bound;
    logic             err;
    fresh_events.delete();
    if (req == REQ_HEARTBEAT) begin
      if (int'(core) >= MonitoredCores) return;
      bound = seq_prev[core] + 32'd1;
      if (count >= bound) begin
        seq_prev[core] = count;
        heard_at[core] = now_at[core];
      end
      return;
    end
    tick_div = tick_div + 8'd1;
    if (tick_div < divisor_cfg) return;
    tick_div = '0;
    for (int c = 0; c < MonitoredCores; c++) begin
      if (now_at[c] != TimeAllOnes) begin
        now_at[c] = now_at[c] + 32'd1;
      end else begin
        now_at[c]   = '0;
        heard_at[c] = '0;
      end
      err = (heard_at[c] > now_at[c]) || ((now_at[c] - heard_at[c]) >= timeout_cfg[c]);
      if (err != lost_flag[c]) fresh_events.push_back('{CoreIdW'(c), err, 1'b0});
      lost_flag[c] = err;
    end
    if (fresh_events.size() != 0) fresh_events[fresh_events.size()-1].last = 1'b1;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (int'(idx) < HW_CORES) timeout_cfg[idx[CoreIdW-1:0]] = data;
    else if (idx == RegRunDivisor) divisor_cfg = data[DivW-1:0];
  endtask

  task automatic transfer_item(logic req, logic [CoreIdW-1:0] core,
                               logic [TimeW-1:0] count, bit book);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    core_id_i       <= core;
    running_count_i <= count;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_monitor(req, core, count);
    if (book) foreach (fresh_events[k]) pending_events.push_back(fresh_events[k]);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic add_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    dir_rows.push_back('{ROW_REG, 2'd0, data, idx, 1'b0, 2'd0, 8'h00});
  endtask

  task automatic add_beat(logic [CoreIdW-1:0] core, logic [TimeW-1:0] count);
    dir_rows.push_back('{ROW_BEAT, core, count, 3'd0, 1'b1, 2'd0, 8'h00});
  endtask

  task automatic add_tick(bit typed, logic [1:0] n, loss_event_t e0, loss_event_t e1);
    dir_rows.push_back('{ROW_TICK, 2'd0, 32'd0, 3'd0, typed, n, {e1, e0}});
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit pause_midway);
    logic [CoreIdW-1:0] c;
    logic [TimeW-1:0]   cnt;
    int                 r;
    settle();
    for (int k = 0; k < HW_CORES; k++) begin
      r = $urandom_range(9);
      if (r == 0) write_reg(CfgIdxW'(k), '0);
      else if (r == 1) write_reg(CfgIdxW'(k), $urandom());
      else write_reg(CfgIdxW'(k), $urandom_range(6, 1));
    end
    write_reg(RegRunDivisor, $urandom_range(3));
    write_reg(RegSpare + CfgIdxW'($urandom_range(2)), $urandom());
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < PhaseItems; n++) begin
      if (pause_midway && n == PhaseItems / 2) settle();
      r = $urandom_range(99);
      c = CoreIdW'($urandom_range(3));
      if (r < 45) begin
        transfer_item(REQ_TICK, c, $urandom(), 1'b1);
      end else begin
        if (r < 80) cnt = seq_prev[c] + 32'd1 + $urandom_range(2);
        else if (r < 90) cnt = seq_prev[c] - $urandom_range(3);
        else cnt = $urandom();
        transfer_item(REQ_HEARTBEAT, c, cnt, 1'b1);
      end
    end
  endtask

  initial begin
    dir_row_t row;
    bit       quiet;
    quiet = 1'b1;
    reset_monitor();

    add_reg(RegTimeout0, 32'd0);
    add_reg(RegTimeout1, 32'd2);
    add_reg(RegTimeout2, TimeAllOnes);
    add_reg(RegTimeout3, 32'd2);
    add_reg(RegRunDivisor, 32'd0);
    add_reg(RegSpare, 32'd3);
    add_tick(1'b1, 2'd1, '{2'd0, 1'b1, 1'b1}, '0);
    add_beat(2'd1, 32'd0);
    add_beat(2'd3, TimeAllOnes);
    add_tick(1'b1, 2'd1, '{2'd1, 1'b1, 1'b1}, '0);
    add_beat(2'd3, 32'd0);
    add_beat(2'd3, 32'd0);
    add_tick(1'b1, 2'd0, '0, '0);
    add_beat(2'd1, 32'd1);
    add_tick(1'b1, 2'd2, '{2'd1, 1'b0, 1'b0}, '{2'd3, 1'b1, 1'b1});
    add_reg(RegRunDivisor, 32'd3);
    add_tick(1'b0, 2'd0, '0, '0);
    add_tick(1'b0, 2'd0, '0, '0);
    add_reg(RegRunDivisor, 32'd1);
    add_tick(1'b0, 2'd0, '0, '0);
    add_reg(RegTimeout0, 32'd3);
    add_reg(RegTimeout1, 32'd3);
    add_reg(RegTimeout2, 32'd3);
    add_reg(RegTimeout3, 32'd3);
    add_beat(2'd0, 32'd5);
    add_beat(2'd1, 32'd2);
    add_beat(2'd2, 32'd7);
    add_beat(2'd3, 32'd1);
    add_tick(1'b0, 2'd0, '0, '0);
    add_tick(1'b0, 2'd0, '0, '0);
    add_tick(1'b0, 2'd0, '0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        if (!quiet) settle();
        quiet = 1'b1;
        write_reg(row.idx, row.val);
      end else begin
        transfer_item((row.kind == ROW_BEAT) ? REQ_HEARTBEAT : REQ_TICK, row.core, row.val,
                      !row.typed);
        if (row.typed) for (int j = 0; j < row.n_typed; j++)
          pending_events.push_back(row.typed_ev[j]);
        quiet = 1'b0;
      end
    end

    settle();
    write_reg(RegRunDivisor, 32'(DivisorMax));
    sender_idle_pct    = 30;
    receiver_stall_pct = 30;
    for (int n = 0; n < SlowTicks; n++) begin
      transfer_item(REQ_TICK, CoreIdW'($urandom()), $urandom(), 1'b1);
    end

    run_phase(0, 0, 1'b0);
    run_phase(73, 0, 1'b1);
    run_phase(0, 73, 1'b0);
    run_phase(30, 30, 1'b0);

    settle();
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
